// ----- rtl/flrp_pkg.sv -----
`default_nettype none

package flrp_pkg;

  localparam logic [7:0]  VERSION_MARKER    = 8'h01;
  localparam logic [16:0] MAX_ENTRIES_RESET = 17'd100000;
  localparam int          FIFO_DEPTH        = 4;
  localparam int          PTR_W             = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    PH_VER,
    PH_CNT,
    PH_CNT_BAD,
    PH_LEN,
    PH_PATH,
    PH_SIZE,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PATH_BYTE = 2'd0,
    KIND_ENTRY     = 2'd1,
    KIND_ACCEPTED  = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SHORT     = 3'd1,
    ERR_VERSION   = 3'd2,
    ERR_COUNT     = 3'd3,
    ERR_TRUNC_LEN = 3'd4,
    ERR_TRUNC_ENT = 3'd5
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [16:0] idx;
    logic [31:0] plen;
    logic [63:0] size;
    err_t        err;
  } result_t;

  function automatic result_t mk_result(kind_t kind, logic [7:0] data, logic [16:0] idx,
                                        logic [31:0] plen, logic [63:0] size, err_t err);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.idx  = idx;
    r.plen = plen;
    r.size = size;
    r.err  = err;
    return r;
  endfunction

  function automatic result_t mk_error(logic [16:0] idx, err_t err);
    return mk_result(KIND_ERROR, 8'd0, idx, 32'd0, 64'd0, err);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/file_list_record_parser.sv -----
// A result is queued on its byte's transfer and shown once earlier results are taken.
// Throughput: one byte per cycle; a byte yields up to two results, held in a
// four-slot result queue, and input stalls while more than two slots are filled.
// Reset: synchronous, active high; clears the parse state and the result queue
// and sets max_entries to 100000.
`default_nettype none

module file_list_record_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic [16:0]      out_entry_index,
  output logic [31:0]      out_path_length,
  output logic [63:0]      out_size,
  output logic [2:0]       out_error
);

  logic [16:0]      max_entries;
  flrp_pkg::phase_t phase, phase_next;
  logic [2:0]       field_byte_count, field_byte_count_next;
  logic [2:0]       header_bytes_seen, header_bytes_seen_next;
  logic [31:0]      entry_count, entry_count_next;
  logic [16:0]      entry_index, entry_index_next;
  logic [31:0]      path_length, path_length_next;
  logic [31:0]      path_remaining, path_remaining_next;
  logic [63:0]      size_accumulator, size_accumulator_next;

  flrp_pkg::result_t res0, res1;
  logic [1:0]        n_res;
  logic              in_acc;
  logic              out_acc;

  flrp_pkg::result_t                fifo [flrp_pkg::FIFO_DEPTH];
  logic [flrp_pkg::PTR_W-1:0]       wptr, rptr;
  logic [flrp_pkg::PTR_W:0]         count;

  assign in_stall  = (count > (flrp_pkg::PTR_W+1)'(flrp_pkg::FIFO_DEPTH - 2));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign out_acc   = out_valid && !out_stall;

  always_comb begin
    phase_next             = phase;
    field_byte_count_next  = field_byte_count;
    header_bytes_seen_next = header_bytes_seen;
    entry_count_next       = entry_count;
    entry_index_next       = entry_index;
    path_length_next       = path_length;
    path_remaining_next    = path_remaining;
    size_accumulator_next  = size_accumulator;
    res0  = '0;
    res1  = '0;
    n_res = 2'd0;
    if (in_acc) begin
      unique case (phase)
        flrp_pkg::PH_VER: begin
          phase_next = (in_byte == flrp_pkg::VERSION_MARKER) ? flrp_pkg::PH_CNT
                                                             : flrp_pkg::PH_CNT_BAD;
          header_bytes_seen_next = 3'd0;
          entry_count_next       = 32'd0;
          if (in_last) begin
            res0  = flrp_pkg::mk_error(17'd0, flrp_pkg::ERR_SHORT);
            n_res = 2'd1;
          end
        end
        flrp_pkg::PH_CNT, flrp_pkg::PH_CNT_BAD: begin
          entry_count_next       = {entry_count[23:0], in_byte};
          header_bytes_seen_next = header_bytes_seen + 3'd1;
          if (header_bytes_seen_next < 3'd4) begin
            if (in_last) begin
              res0  = flrp_pkg::mk_error(17'd0, flrp_pkg::ERR_SHORT);
              n_res = 2'd1;
            end
          end else if (phase == flrp_pkg::PH_CNT_BAD) begin
            res0       = flrp_pkg::mk_error(17'd0, flrp_pkg::ERR_VERSION);
            n_res      = 2'd1;
            phase_next = flrp_pkg::PH_SKIP;
          end else if (entry_count_next > {15'd0, max_entries}) begin
            res0       = flrp_pkg::mk_error(17'd0, flrp_pkg::ERR_COUNT);
            n_res      = 2'd1;
            phase_next = flrp_pkg::PH_SKIP;
          end else if (entry_count_next == 32'd0) begin
            res0 = flrp_pkg::mk_result(flrp_pkg::KIND_ACCEPTED, 8'd0, 17'd0, 32'd0, 64'd0,
                                       flrp_pkg::ERR_NONE);
            n_res      = 2'd1;
            phase_next = flrp_pkg::PH_SKIP;
          end else begin
            entry_index_next      = 17'd0;
            phase_next            = flrp_pkg::PH_LEN;
            field_byte_count_next = 3'd0;
            path_length_next      = 32'd0;
            if (in_last) begin
              res0  = flrp_pkg::mk_error(17'd0, flrp_pkg::ERR_TRUNC_LEN);
              n_res = 2'd1;
            end
          end
        end
        flrp_pkg::PH_LEN: begin
          path_length_next      = {path_length[23:0], in_byte};
          field_byte_count_next = field_byte_count + 3'd1;
          if (field_byte_count != 3'd3) begin
            if (in_last) begin
              res0  = flrp_pkg::mk_error(entry_index, flrp_pkg::ERR_TRUNC_LEN);
              n_res = 2'd1;
            end
          end else begin
            path_remaining_next   = path_length_next;
            field_byte_count_next = 3'd0;
            size_accumulator_next = 64'd0;
            phase_next = (path_length_next != 32'd0) ? flrp_pkg::PH_PATH : flrp_pkg::PH_SIZE;
            if (in_last) begin
              res0  = flrp_pkg::mk_error(entry_index, flrp_pkg::ERR_TRUNC_ENT);
              n_res = 2'd1;
            end
          end
        end
        flrp_pkg::PH_PATH: begin
          res0 = flrp_pkg::mk_result(flrp_pkg::KIND_PATH_BYTE, in_byte, entry_index, 32'd0,
                                     64'd0, flrp_pkg::ERR_NONE);
          n_res               = 2'd1;
          path_remaining_next = path_remaining - 32'd1;
          if (path_remaining_next == 32'd0) begin
            phase_next = flrp_pkg::PH_SIZE;
          end
          if (in_last) begin
            res1  = flrp_pkg::mk_error(entry_index, flrp_pkg::ERR_TRUNC_ENT);
            n_res = 2'd2;
          end
        end
        flrp_pkg::PH_SIZE: begin
          size_accumulator_next = {size_accumulator[55:0], in_byte};
          field_byte_count_next = field_byte_count + 3'd1;
          if (field_byte_count != 3'd7) begin
            if (in_last) begin
              res0  = flrp_pkg::mk_error(entry_index, flrp_pkg::ERR_TRUNC_ENT);
              n_res = 2'd1;
            end
          end else begin
            res0 = flrp_pkg::mk_result(flrp_pkg::KIND_ENTRY, 8'd0, entry_index, path_length,
                                       size_accumulator_next, flrp_pkg::ERR_NONE);
            n_res = 2'd1;
            if ({1'b0, entry_index} + 18'd1 >= entry_count[17:0]) begin
              res1 = flrp_pkg::mk_result(flrp_pkg::KIND_ACCEPTED, 8'd0, entry_count[16:0],
                                         32'd0, 64'd0, flrp_pkg::ERR_NONE);
              n_res      = 2'd2;
              phase_next = flrp_pkg::PH_SKIP;
            end else begin
              entry_index_next      = entry_index + 17'd1;
              phase_next            = flrp_pkg::PH_LEN;
              field_byte_count_next = 3'd0;
              path_length_next      = 32'd0;
              if (in_last) begin
                res1  = flrp_pkg::mk_error(entry_index_next, flrp_pkg::ERR_TRUNC_LEN);
                n_res = 2'd2;
              end
            end
          end
        end
        flrp_pkg::PH_SKIP: begin
        end
        default: begin
        end
      endcase
      if (in_last) begin
        phase_next             = flrp_pkg::PH_VER;
        field_byte_count_next  = 3'd0;
        header_bytes_seen_next = 3'd0;
        entry_count_next       = 32'd0;
        entry_index_next       = 17'd0;
        path_length_next       = 32'd0;
        path_remaining_next    = 32'd0;
        size_accumulator_next  = 64'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries       <= flrp_pkg::MAX_ENTRIES_RESET;
      phase             <= flrp_pkg::PH_VER;
      field_byte_count  <= 3'd0;
      header_bytes_seen <= 3'd0;
      entry_count       <= 32'd0;
      entry_index       <= 17'd0;
      path_length       <= 32'd0;
      path_remaining    <= 32'd0;
      size_accumulator  <= 64'd0;
    end else begin
      if (cfg_we) begin
        max_entries <= cfg_wdata;
      end
      phase             <= phase_next;
      field_byte_count  <= field_byte_count_next;
      header_bytes_seen <= header_bytes_seen_next;
      entry_count       <= entry_count_next;
      entry_index       <= entry_index_next;
      path_length       <= path_length_next;
      path_remaining    <= path_remaining_next;
      size_accumulator  <= size_accumulator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + flrp_pkg::PTR_W'(n_res);
      rptr  <= rptr + flrp_pkg::PTR_W'(out_acc);
      count <= count + (flrp_pkg::PTR_W+1)'(n_res) - (flrp_pkg::PTR_W+1)'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      fifo[wptr] <= res0;
    end
    if (n_res == 2'd2) begin
      fifo[wptr + flrp_pkg::PTR_W'(1)] <= res1;
    end
  end

  assign out_kind        = fifo[rptr].kind;
  assign out_byte        = fifo[rptr].data;
  assign out_entry_index = fifo[rptr].idx;
  assign out_path_length = fifo[rptr].plen;
  assign out_size        = fifo[rptr].size;
  assign out_error       = fifo[rptr].err;

endmodule

`default_nettype wire

// ----- rtl/flrp_checker.sv -----
`default_nettype none

module flrp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_kind,
  input wire logic [7:0]  out_byte,
  input wire logic [31:0] out_path_length,
  input wire logic [63:0] out_size,
  input wire logic [2:0]  out_error
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_kind == flrp_pkg::KIND_ERROR) == (out_error != flrp_pkg::ERR_NONE)))
    else $error("error code does not match result kind");

  a_path_byte_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == flrp_pkg::KIND_PATH_BYTE) |->
      (out_path_length == 32'd0 && out_size == 64'd0))
    else $error("path byte carries entry fields");

  a_data_only_path: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != flrp_pkg::KIND_PATH_BYTE) |-> (out_byte == 8'd0))
    else $error("byte field set outside path byte");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_kind) && $stable(out_size)))
    else $error("stalled transfer changed");

endmodule

bind file_list_record_parser flrp_checker u_flrp_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_byte        (out_byte),
  .out_path_length (out_path_length),
  .out_size        (out_size),
  .out_error       (out_error)
);

`default_nettype wire
